>>> hw/rtl/ccpt_pkg.sv
// Shared widths, beat types and limits for the circumcircle point test.
package ccpt_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int SQ_W       = 2 * DIFF_W + 1;
   localparam int DET_W      = 2 * DIFF_W + 1;
   localparam int NUM_W      = DIFF_W + SQ_W + 1;
   localparam int LHS_W      = SQ_W + DET_W;
   localparam int DOT_W      = DIFF_W + NUM_W + 1;
   localparam int SUM_W      = 2 * NUM_W + 1;
   localparam int DIV_N_W    = SUM_W;
   localparam int DIV_D_W    = 2 * DET_W + 2;
   localparam int RAD_W      = 31;
   localparam int ROOT_IN_W  = 2 * RAD_W;
   localparam int CTR_W      = 32;

   localparam logic signed [CTR_W-1:0] CTR_MAX = {1'b0, {(CTR_W-1){1'b1}}};
   localparam logic signed [CTR_W-1:0] CTR_MIN = {1'b1, {(CTR_W-1){1'b0}}};
   localparam logic [RAD_W-1:0]        RAD_MAX = {RAD_W{1'b1}};

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic signed [COORD_BITS-1:0] c_x;
      logic signed [COORD_BITS-1:0] c_y;
      logic signed [COORD_BITS-1:0] query_x;
      logic signed [COORD_BITS-1:0] query_y;
   } req_type;

   typedef struct packed {
      logic                    inside_res;
      logic signed [CTR_W-1:0] center_x;
      logic signed [CTR_W-1:0] center_y;
      logic [RAD_W-1:0]        radius;
      logic                    degenerate;
   } rsp_type;

endpackage

>>> hw/rtl/circumcircle_point_test.sv
// Top level: circumcenter, circumradius and in-circle test for one triangle per beat.
// Throughput: one beat per cycle; busy is never raised and the pipeline never stalls.
// The depth is set by the 62-stage quotient divider and the 31-stage square root.
// Reset clears every valid bit; beats in flight are dropped, payload is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module circumcircle_point_test (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ccpt_pkg::req_type req_item,
   output logic              rsp_strobe,
   output ccpt_pkg::rsp_type rsp_item
);

   localparam int CB      = ccpt_pkg::COORD_BITS;
   localparam int DW      = ccpt_pkg::DIFF_W;
   localparam int SQW     = ccpt_pkg::SQ_W;
   localparam int DETW    = ccpt_pkg::DET_W;
   localparam int NW      = ccpt_pkg::NUM_W;
   localparam int LW      = ccpt_pkg::LHS_W;
   localparam int OW      = ccpt_pkg::DOT_W;
   localparam int SW      = ccpt_pkg::SUM_W;
   localparam int DNW     = ccpt_pkg::DIV_N_W;
   localparam int DDW     = ccpt_pkg::DIV_D_W;
   localparam int QW      = ccpt_pkg::ROOT_IN_W;
   localparam int RW      = ccpt_pkg::RAD_W;
   localparam int CW      = ccpt_pkg::CTR_W;
   localparam int CMPW    = (LW > OW) ? LW : OW;
   localparam int LATENCY = 1 + 3 + 1 + 3 + 1 + 3 + 1 + (1 + QW) + (1 + RW) + 1;

   typedef struct packed {
      logic signed [CB-1:0] ax;
      logic signed [CB-1:0] ay;
      logic signed [DW-1:0] bx;
      logic signed [DW-1:0] by;
      logic signed [DW-1:0] cx;
      logic signed [DW-1:0] cy;
      logic signed [DW-1:0] qx;
      logic signed [DW-1:0] qy;
   } s1_tag_type;

   typedef struct packed {
      logic signed [CB-1:0]   ax;
      logic signed [CB-1:0]   ay;
      logic signed [DW-1:0]   qx;
      logic signed [DW-1:0]   qy;
      logic signed [DETW-1:0] det;
   } s2_tag_type;

   typedef struct packed {
      logic signed [CB-1:0] ax;
      logic signed [CB-1:0] ay;
      logic [DETW-1:0]      dabs;
      logic signed [LW-1:0] lhs;
      logic                 zero;
   } s3_tag_type;

   typedef struct packed {
      logic signed [CB-1:0] ax;
      logic signed [CB-1:0] ay;
      logic                 negx;
      logic                 negy;
      logic                 in_circle;
      logic                 zero;
   } s4_tag_type;

   typedef struct packed {
      logic                 zero;
      logic                 in_circle;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic                 ovfr;
   } s5_tag_type;

   // Center = a + q with q = +/- quotient; saturate to the 32-bit range.
   function automatic logic signed [CW-1:0] center_sat(
      input logic signed [CB-1:0] a,
      input logic [QW-1:0]        q,
      input logic                 ovf,
      input logic                 neg
   );
      logic signed [QW+1:0] sq;
      logic signed [QW+1:0] tot;
      logic signed [CW-1:0] res;
      sq  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      tot = sq + (QW+2)'(a);
      if (ovf) begin
         res = neg ? ccpt_pkg::CTR_MIN : ccpt_pkg::CTR_MAX;
      end else if (tot > (QW+2)'(ccpt_pkg::CTR_MAX)) begin
         res = ccpt_pkg::CTR_MAX;
      end else if (tot < (QW+2)'(ccpt_pkg::CTR_MIN)) begin
         res = ccpt_pkg::CTR_MIN;
      end else begin
         res = tot[CW-1:0];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Capture: shift everything so vertex a sits at the origin.
   // ---------------------------------------------------------------
   logic       s0_v_ff;
   s1_tag_type s0_tag_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s0_tag_ff.ax <= req_item.a_x;
      s0_tag_ff.ay <= req_item.a_y;
      s0_tag_ff.bx <= DW'(req_item.b_x) - DW'(req_item.a_x);
      s0_tag_ff.by <= DW'(req_item.b_y) - DW'(req_item.a_y);
      s0_tag_ff.cx <= DW'(req_item.c_x) - DW'(req_item.a_x);
      s0_tag_ff.cy <= DW'(req_item.c_y) - DW'(req_item.a_y);
      s0_tag_ff.qx <= DW'(req_item.query_x) - DW'(req_item.a_x);
      s0_tag_ff.qy <= DW'(req_item.query_y) - DW'(req_item.a_y);
   end

   // ---------------------------------------------------------------
   // First product bank: squares and cross terms of the offsets.
   // ---------------------------------------------------------------
   logic                   m1_v;
   s1_tag_type             m1_tag;
   logic signed [2*DW-1:0] p_bxbx, p_byby, p_cxcx, p_cycy;
   logic signed [2*DW-1:0] p_bxcy, p_bycx, p_qxqx, p_qyqy;

   ccpt_mul #(.A_W(DW), .B_W(DW), .TAG_W($bits(s1_tag_type))) u_m1_bxbx (
      .clock, .reset, .in_valid(s0_v_ff), .in_a(s0_tag_ff.bx), .in_b(s0_tag_ff.bx),
      .in_tag(s0_tag_ff), .out_valid(m1_v), .out_p(p_bxbx), .out_tag(m1_tag));
   ccpt_mul #(.A_W(DW), .B_W(DW), .TAG_W(1)) u_m1_byby (
      .clock, .reset, .in_valid(s0_v_ff), .in_a(s0_tag_ff.by), .in_b(s0_tag_ff.by),
      .in_tag(1'b0), .out_valid(), .out_p(p_byby), .out_tag());
   ccpt_mul #(.A_W(DW), .B_W(DW), .TAG_W(1)) u_m1_cxcx (
      .clock, .reset, .in_valid(s0_v_ff), .in_a(s0_tag_ff.cx), .in_b(s0_tag_ff.cx),
      .in_tag(1'b0), .out_valid(), .out_p(p_cxcx), .out_tag());
   ccpt_mul #(.A_W(DW), .B_W(DW), .TAG_W(1)) u_m1_cycy (
      .clock, .reset, .in_valid(s0_v_ff), .in_a(s0_tag_ff.cy), .in_b(s0_tag_ff.cy),
      .in_tag(1'b0), .out_valid(), .out_p(p_cycy), .out_tag());
   ccpt_mul #(.A_W(DW), .B_W(DW), .TAG_W(1)) u_m1_bxcy (
      .clock, .reset, .in_valid(s0_v_ff), .in_a(s0_tag_ff.bx), .in_b(s0_tag_ff.cy),
      .in_tag(1'b0), .out_valid(), .out_p(p_bxcy), .out_tag());
   ccpt_mul #(.A_W(DW), .B_W(DW), .TAG_W(1)) u_m1_bycx (
      .clock, .reset, .in_valid(s0_v_ff), .in_a(s0_tag_ff.by), .in_b(s0_tag_ff.cx),
      .in_tag(1'b0), .out_valid(), .out_p(p_bycx), .out_tag());
   ccpt_mul #(.A_W(DW), .B_W(DW), .TAG_W(1)) u_m1_qxqx (
      .clock, .reset, .in_valid(s0_v_ff), .in_a(s0_tag_ff.qx), .in_b(s0_tag_ff.qx),
      .in_tag(1'b0), .out_valid(), .out_p(p_qxqx), .out_tag());
   ccpt_mul #(.A_W(DW), .B_W(DW), .TAG_W(1)) u_m1_qyqy (
      .clock, .reset, .in_valid(s0_v_ff), .in_a(s0_tag_ff.qy), .in_b(s0_tag_ff.qy),
      .in_tag(1'b0), .out_valid(), .out_p(p_qyqy), .out_tag());

   // Stage A: squared lengths and the determinant D.
   logic                    a_v_ff;
   s1_tag_type              a_tag_ff;
   logic signed [SQW-1:0]   a_b2_ff, a_c2_ff, a_q2_ff;
   logic signed [DETW-1:0]  a_det_ff;
   s2_tag_type              a_t2;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= m1_v;
      end
   end

   always_ff @(posedge clock) begin
      a_tag_ff <= m1_tag;
      a_b2_ff  <= SQW'(p_bxbx) + SQW'(p_byby);
      a_c2_ff  <= SQW'(p_cxcx) + SQW'(p_cycy);
      a_q2_ff  <= SQW'(p_qxqx) + SQW'(p_qyqy);
      a_det_ff <= DETW'(p_bxcy) - DETW'(p_bycx);
   end

   assign a_t2.ax  = a_tag_ff.ax;
   assign a_t2.ay  = a_tag_ff.ay;
   assign a_t2.qx  = a_tag_ff.qx;
   assign a_t2.qy  = a_tag_ff.qy;
   assign a_t2.det = a_det_ff;

   // ---------------------------------------------------------------
   // Second product bank: numerator terms and the |q'|^2 * D side.
   // ---------------------------------------------------------------
   logic                      m2_v;
   s2_tag_type                m2_tag;
   logic signed [DW+SQW-1:0]  p_cyb2, p_byc2, p_bxc2, p_cxb2;
   logic signed [LW-1:0]      p_q2d;

   ccpt_mul #(.A_W(DW), .B_W(SQW), .TAG_W($bits(s2_tag_type))) u_m2_cyb2 (
      .clock, .reset, .in_valid(a_v_ff), .in_a(a_tag_ff.cy), .in_b(a_b2_ff),
      .in_tag(a_t2), .out_valid(m2_v), .out_p(p_cyb2), .out_tag(m2_tag));
   ccpt_mul #(.A_W(DW), .B_W(SQW), .TAG_W(1)) u_m2_byc2 (
      .clock, .reset, .in_valid(a_v_ff), .in_a(a_tag_ff.by), .in_b(a_c2_ff),
      .in_tag(1'b0), .out_valid(), .out_p(p_byc2), .out_tag());
   ccpt_mul #(.A_W(DW), .B_W(SQW), .TAG_W(1)) u_m2_bxc2 (
      .clock, .reset, .in_valid(a_v_ff), .in_a(a_tag_ff.bx), .in_b(a_c2_ff),
      .in_tag(1'b0), .out_valid(), .out_p(p_bxc2), .out_tag());
   ccpt_mul #(.A_W(DW), .B_W(SQW), .TAG_W(1)) u_m2_cxb2 (
      .clock, .reset, .in_valid(a_v_ff), .in_a(a_tag_ff.cx), .in_b(a_b2_ff),
      .in_tag(1'b0), .out_valid(), .out_p(p_cxb2), .out_tag());
   ccpt_mul #(.A_W(SQW), .B_W(DETW), .TAG_W(1)) u_m2_q2d (
      .clock, .reset, .in_valid(a_v_ff), .in_a(a_q2_ff), .in_b(a_det_ff),
      .in_tag(1'b0), .out_valid(), .out_p(p_q2d), .out_tag());

   // Stage B: form N, then flip signs so D is positive.
   logic                   b_v_ff;
   logic signed [CB-1:0]   b_ax_ff, b_ay_ff;
   logic signed [DW-1:0]   b_qx_ff, b_qy_ff;
   logic signed [NW-1:0]   b_nx_ff, b_ny_ff, nx_in, ny_in;
   logic [DETW-1:0]        b_dabs_ff;
   logic signed [LW-1:0]   b_lhs_ff;
   logic                   b_zero_ff, det_neg;
   s3_tag_type             b_t3;

   assign nx_in   = NW'(p_cyb2) - NW'(p_byc2);
   assign ny_in   = NW'(p_bxc2) - NW'(p_cxb2);
   assign det_neg = m2_tag.det[DETW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else begin
         b_v_ff <= m2_v;
      end
   end

   always_ff @(posedge clock) begin
      b_ax_ff   <= m2_tag.ax;
      b_ay_ff   <= m2_tag.ay;
      b_qx_ff   <= m2_tag.qx;
      b_qy_ff   <= m2_tag.qy;
      b_nx_ff   <= det_neg ? -nx_in : nx_in;
      b_ny_ff   <= det_neg ? -ny_in : ny_in;
      b_lhs_ff  <= det_neg ? -p_q2d : p_q2d;
      b_dabs_ff <= det_neg ? DETW'(-m2_tag.det) : DETW'(m2_tag.det);
      b_zero_ff <= m2_tag.det == '0;
   end

   assign b_t3.ax   = b_ax_ff;
   assign b_t3.ay   = b_ay_ff;
   assign b_t3.dabs = b_dabs_ff;
   assign b_t3.lhs  = b_lhs_ff;
   assign b_t3.zero = b_zero_ff;

   // ---------------------------------------------------------------
   // Third product bank: |N|^2, q'.N and D^2.
   // ---------------------------------------------------------------
   logic                    m3_v;
   s3_tag_type              m3_tag;
   logic signed [2*NW-1:0]  p_nxnx, p_nyny;
   logic signed [DW+NW-1:0] p_qxnx, p_qyny;
   logic signed [DDW-1:0]   p_dd;
   logic signed [DETW:0]    dabs_s;

   assign dabs_s = $signed({1'b0, b_dabs_ff});

   ccpt_mul #(.A_W(NW), .B_W(NW), .TAG_W($bits(s3_tag_type))) u_m3_nxnx (
      .clock, .reset, .in_valid(b_v_ff), .in_a(b_nx_ff), .in_b(b_nx_ff),
      .in_tag(b_t3), .out_valid(m3_v), .out_p(p_nxnx), .out_tag(m3_tag));
   ccpt_mul #(.A_W(NW), .B_W(NW), .TAG_W(1)) u_m3_nyny (
      .clock, .reset, .in_valid(b_v_ff), .in_a(b_ny_ff), .in_b(b_ny_ff),
      .in_tag(1'b0), .out_valid(), .out_p(p_nyny), .out_tag());
   ccpt_mul #(.A_W(DW), .B_W(NW), .TAG_W(1)) u_m3_qxnx (
      .clock, .reset, .in_valid(b_v_ff), .in_a(b_qx_ff), .in_b(b_nx_ff),
      .in_tag(1'b0), .out_valid(), .out_p(p_qxnx), .out_tag());
   ccpt_mul #(.A_W(DW), .B_W(NW), .TAG_W(1)) u_m3_qyny (
      .clock, .reset, .in_valid(b_v_ff), .in_a(b_qy_ff), .in_b(b_ny_ff),
      .in_tag(1'b0), .out_valid(), .out_p(p_qyny), .out_tag());
   ccpt_mul #(.A_W(DETW+1), .B_W(DETW+1), .TAG_W(1)) u_m3_dd (
      .clock, .reset, .in_valid(b_v_ff), .in_a(dabs_s), .in_b(dabs_s),
      .in_tag(1'b0), .out_valid(), .out_p(p_dd), .out_tag());

   // Stage C: in-circle decision and the divider operands.
   // Floor of a negative n over 2D runs as -((-n + 2D - 1) / 2D).
   logic                 c_v_ff;
   s4_tag_type           c_t4_ff;
   logic [SW-1:0]        c_sum_ff;
   logic [DDW-1:0]       c_fourdd_ff;
   logic [NW+1:0]        c_mx_ff, c_my_ff;
   logic [DETW:0]        c_twod_ff;
   logic signed [OW-1:0] rhs;
   logic signed [NW+1:0] nxd, nyd, twod_w;
   logic signed [NW:0]   nxe, nye;
   logic                 inside_in;

   // N from stage B travels beside the third bank.
   logic signed [NW-1:0] nx_d3_ff [0:2];
   logic signed [NW-1:0] ny_d3_ff [0:2];

   assign rhs       = OW'(p_qxnx) + OW'(p_qyny);
   assign inside_in = !m3_tag.zero && (CMPW'(rhs) >= CMPW'(m3_tag.lhs));
   assign twod_w    = $signed((NW+2)'({m3_tag.dabs, 1'b0}));
   assign nxe       = (NW+1)'(nx_d3_ff[2]) + $signed((NW+1)'(m3_tag.dabs));
   assign nye       = (NW+1)'(ny_d3_ff[2]) + $signed((NW+1)'(m3_tag.dabs));
   assign nxd       = (NW+2)'(nxe);
   assign nyd       = (NW+2)'(nye);

   always_ff @(posedge clock) begin
      nx_d3_ff[0] <= b_nx_ff;
      ny_d3_ff[0] <= b_ny_ff;
      nx_d3_ff[1] <= nx_d3_ff[0];
      ny_d3_ff[1] <= ny_d3_ff[0];
      nx_d3_ff[2] <= nx_d3_ff[1];
      ny_d3_ff[2] <= ny_d3_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else begin
         c_v_ff <= m3_v;
      end
   end

   always_ff @(posedge clock) begin
      c_t4_ff.ax        <= m3_tag.ax;
      c_t4_ff.ay        <= m3_tag.ay;
      c_t4_ff.negx      <= nxd[NW+1];
      c_t4_ff.negy      <= nyd[NW+1];
      c_t4_ff.in_circle <= inside_in;
      c_t4_ff.zero      <= m3_tag.zero;
      c_sum_ff          <= SW'(p_nxnx) + SW'(p_nyny);
      c_fourdd_ff       <= {p_dd[DDW-3:0], 2'b00};
      c_twod_ff         <= {m3_tag.dabs, 1'b0};
      c_mx_ff           <= nxd[NW+1] ? (twod_w - nxd - 1'b1) : nxd;
      c_my_ff           <= nyd[NW+1] ? (twod_w - nyd - 1'b1) : nyd;
   end

   // ---------------------------------------------------------------
   // Dividers: both center quotients and |N|^2 / (4 D^2) side by side.
   // ---------------------------------------------------------------
   logic          dv_v;
   s4_tag_type    dv_tag;
   logic [QW-1:0] q_x, q_y, q_r;
   logic          ovf_x, ovf_y, ovf_r;
   s5_tag_type    sq_tag_in, sq_tag;
   logic          sq_v;
   logic [RW-1:0] root;

   ccpt_div #(.N_W(DNW), .D_W(DDW), .Q_W(QW), .TAG_W($bits(s4_tag_type))) u_div_r (
      .clock, .reset, .in_valid(c_v_ff), .in_num(c_sum_ff), .in_den(c_fourdd_ff),
      .in_tag(c_t4_ff), .out_valid(dv_v), .out_q(q_r), .out_ovf(ovf_r),
      .out_tag(dv_tag));
   ccpt_div #(.N_W(DNW), .D_W(DDW), .Q_W(QW), .TAG_W(1)) u_div_x (
      .clock, .reset, .in_valid(c_v_ff), .in_num(DNW'(c_mx_ff)),
      .in_den(DDW'(c_twod_ff)), .in_tag(1'b0), .out_valid(), .out_q(q_x),
      .out_ovf(ovf_x), .out_tag());
   ccpt_div #(.N_W(DNW), .D_W(DDW), .Q_W(QW), .TAG_W(1)) u_div_y (
      .clock, .reset, .in_valid(c_v_ff), .in_num(DNW'(c_my_ff)),
      .in_den(DDW'(c_twod_ff)), .in_tag(1'b0), .out_valid(), .out_q(q_y),
      .out_ovf(ovf_y), .out_tag());

   // Fold the center quotients into saturated coordinates on the way in.
   assign sq_tag_in.zero      = dv_tag.zero;
   assign sq_tag_in.in_circle = dv_tag.in_circle;
   assign sq_tag_in.cx        = center_sat(dv_tag.ax, q_x, ovf_x, dv_tag.negx);
   assign sq_tag_in.cy        = center_sat(dv_tag.ay, q_y, ovf_y, dv_tag.negy);
   assign sq_tag_in.ovfr      = ovf_r;

   ccpt_sqrt #(.R_W(RW), .TAG_W($bits(s5_tag_type))) u_sqrt (
      .clock, .reset, .in_valid(dv_v), .in_val(q_r), .in_tag(sq_tag_in),
      .out_valid(sq_v), .out_root(root), .out_tag(sq_tag));

   // ---------------------------------------------------------------
   // Output register: collinear vertices clear every field but the flag.
   // ---------------------------------------------------------------
   logic              rsp_strobe_ff;
   ccpt_pkg::rsp_type rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff.degenerate <= sq_tag.zero;
      rsp_item_ff.inside_res <= sq_tag.in_circle && !sq_tag.zero;
      rsp_item_ff.center_x   <= sq_tag.zero ? '0 : sq_tag.cx;
      rsp_item_ff.center_y   <= sq_tag.zero ? '0 : sq_tag.cy;
      rsp_item_ff.radius     <= sq_tag.zero ? '0 :
                                (sq_tag.ovfr ? ccpt_pkg::RAD_MAX : root);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef SYNTHESIS
   // Every result beat traces back to a start beat at the pipeline depth given by LATENCY.
   a_rsp_from_start : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("result beat without matching start beat");

   // Collinear vertices report only the flag.
   a_degenerate_clear : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.degenerate |->
         !rsp_item.inside_res && rsp_item.radius == '0 &&
         rsp_item.center_x == '0 && rsp_item.center_y == '0)
      else $error("degenerate beat carries nonzero fields");
`endif

endmodule

>>> hw/rtl/ccpt_mul.sv
// Pipelined signed multiplier built from four half-width partial products.
module ccpt_mul #(
   parameter int A_W   = 17,
   parameter int B_W   = 17,
   parameter int TAG_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [A_W-1:0]   in_a,
   input  logic signed [B_W-1:0]   in_b,
   input  logic [TAG_W-1:0]        in_tag,
   output logic                    out_valid,
   output logic signed [A_W+B_W-1:0] out_p,
   output logic [TAG_W-1:0]        out_tag
);

   localparam int HA  = (A_W + 1) / 2;
   localparam int HB  = (B_W + 1) / 2;
   localparam int P_W = A_W + B_W;

   logic [A_W-1:0] mag_a_in, mag_a_ff;
   logic [B_W-1:0] mag_b_in, mag_b_ff;
   logic           neg1_ff, neg2_ff, neg3_in;
   logic [2:0]     v_ff;
   logic [TAG_W-1:0] tag1_ff, tag2_ff, tag3_ff;

   logic [HA+HB-1:0]                 pp_ll_ff;
   logic [HA+(B_W-HB)-1:0]           pp_lh_ff;
   logic [(A_W-HA)+HB-1:0]           pp_hl_ff;
   logic [(A_W-HA)+(B_W-HB)-1:0]     pp_hh_ff;
   logic [P_W-1:0]                   sum_in;
   logic signed [P_W-1:0]            p_in, p_ff;

   assign mag_a_in = in_a[A_W-1] ? (~in_a + 1'b1) : in_a;
   assign mag_b_in = in_b[B_W-1] ? (~in_b + 1'b1) : in_b;

   assign sum_in = (P_W'(pp_hh_ff) << (HA + HB)) + (P_W'(pp_hl_ff) << HA)
                 + (P_W'(pp_lh_ff) << HB) + P_W'(pp_ll_ff);
   assign neg3_in = neg2_ff;
   assign p_in    = neg3_in ? (~sum_in + 1'b1) : sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg1_ff  <= in_a[A_W-1] ^ in_b[B_W-1];
      tag1_ff  <= in_tag;
      pp_ll_ff <= mag_a_ff[HA-1:0] * mag_b_ff[HB-1:0];
      pp_lh_ff <= mag_a_ff[HA-1:0] * mag_b_ff[B_W-1:HB];
      pp_hl_ff <= mag_a_ff[A_W-1:HA] * mag_b_ff[HB-1:0];
      pp_hh_ff <= mag_a_ff[A_W-1:HA] * mag_b_ff[B_W-1:HB];
      neg2_ff  <= neg1_ff;
      tag2_ff  <= tag1_ff;
      p_ff     <= p_in;
      tag3_ff  <= tag2_ff;
   end

   assign out_valid = v_ff[2];
   assign out_p     = p_ff;
   assign out_tag   = tag3_ff;

endmodule

>>> hw/rtl/ccpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module ccpt_div #(
   parameter int N_W   = 107,
   parameter int D_W   = 72,
   parameter int Q_W   = 62,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [N_W-1:0]   in_num,
   input  logic [D_W-1:0]   in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_q,
   output logic             out_ovf,
   output logic [TAG_W-1:0] out_tag
);

   localparam int H_W   = N_W - Q_W;
   localparam int CMP_W = (H_W > D_W) ? H_W : D_W;

   logic             v_ff   [0:Q_W];
   logic [TAG_W-1:0] tag_ff [0:Q_W];
   logic [D_W-1:0]   den_ff [0:Q_W];
   logic [D_W-1:0]   rem_ff [0:Q_W];
   logic [Q_W-1:0]   lq_ff  [0:Q_W];
   logic             ovf_ff [0:Q_W];
   logic [H_W-1:0]   hi;

   assign hi = in_num[N_W-1:Q_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   // quotient overflows when the high part alone reaches the divisor
   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tag;
      den_ff[0] <= in_den;
      rem_ff[0] <= D_W'(hi);
      lq_ff[0]  <= in_num[Q_W-1:0];
      ovf_ff[0] <= CMP_W'(hi) >= CMP_W'(in_den);
   end

   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      logic [D_W:0] trial;
      logic         ge;

      assign trial = {rem_ff[i], lq_ff[i][Q_W-1]};
      assign ge    = trial >= {1'b0, den_ff[i]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      // shift the next numerator bit in, the quotient bit out
      always_ff @(posedge clock) begin
         rem_ff[i+1] <= ge ? D_W'(trial - {1'b0, den_ff[i]}) : D_W'(trial);
         lq_ff[i+1]  <= {lq_ff[i][Q_W-2:0], ge};
         den_ff[i+1] <= den_ff[i];
         ovf_ff[i+1] <= ovf_ff[i];
         tag_ff[i+1] <= tag_ff[i];
      end
   end

   assign out_valid = v_ff[Q_W];
   assign out_q     = lq_ff[Q_W];
   assign out_ovf   = ovf_ff[Q_W];
   assign out_tag   = tag_ff[Q_W];

endmodule

>>> hw/rtl/ccpt_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module ccpt_sqrt #(
   parameter int R_W   = 31,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [2*R_W-1:0] in_val,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [R_W-1:0]   out_root,
   output logic [TAG_W-1:0] out_tag
);

   localparam int V_W = 2 * R_W;

   logic             v_ff   [0:R_W];
   logic [TAG_W-1:0] tag_ff [0:R_W];
   logic [V_W-1:0]   val_ff [0:R_W];
   logic [R_W-1:0]   r_ff   [0:R_W];
   logic [V_W-1:0]   r2_ff  [0:R_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tag;
      val_ff[0] <= in_val;
      r_ff[0]   <= '0;
      r2_ff[0]  <= '0;
   end

   for (genvar i = 0; i < R_W; i++) begin : g_stage
      localparam int B = R_W - 1 - i;
      logic [V_W-1:0] t2;
      logic           take;

      // (r + 2^B)^2 = r^2 + r*2^(B+1) + 2^(2B)
      assign t2   = r2_ff[i] + (V_W'(r_ff[i]) << (B + 1)) + (V_W'(1) << (2 * B));
      assign take = t2 <= val_ff[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         r_ff[i+1]   <= take ? (r_ff[i] | (R_W'(1) << B)) : r_ff[i];
         r2_ff[i+1]  <= take ? t2 : r2_ff[i];
         val_ff[i+1] <= val_ff[i];
         tag_ff[i+1] <= tag_ff[i];
      end
   end

   assign out_valid = v_ff[R_W];
   assign out_root  = r_ff[R_W];
   assign out_tag   = tag_ff[R_W];

endmodule
